FILE: src/ac3hdc_pkg.sv
// Types, constants and lookup functions for the AC-3 header decode and compare unit.
package ac3hdc_pkg;

    localparam logic [7:0] SYNC_HI      = 8'h0B;
    localparam logic [7:0] SYNC_LO      = 8'h77;
    localparam logic [7:0] BSID_LIMIT   = 8'h60;
    localparam logic [5:0] FRM_MAX      = 6'h25;
    localparam logic [7:0] FRM_PAD_MASK = 8'hFE;
    localparam logic [4:0] HALF_BASE    = 5'd8;

    localparam logic [1:0] FSCOD_48K = 2'd0;
    localparam logic [1:0] FSCOD_44K = 2'd1;
    localparam logic [1:0] FSCOD_32K = 2'd2;
    localparam logic [1:0] FSCOD_RSV = 2'd3;

    localparam logic [2:0] ACMOD_STEREO = 3'd2;
    localparam logic [1:0] DSURMOD_ON   = 2'd2;

    localparam logic [15:0] RATE_48K = 16'd48000;
    localparam logic [15:0] RATE_44K = 16'd44100;
    localparam logic [15:0] RATE_32K = 16'd32000;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_four;
        logic [7:0] byte_five;
        logic [7:0] byte_six;
        logic [7:0] byte_seven;
    } hdr_in_t;

    typedef struct packed {
        logic        header_ok;
        logic        little_endian;
        logic [11:0] frame_bytes;
        logic [15:0] audio_rate_hz;
        logic [2:0]  channel_mode;
        logic        lfe_present;
        logic        dolby_surround;
        logic        same_as_reference;
    } hdr_out_t;

    // bit rate in kbit/s for frmsizecod >> 1
    function automatic logic [9:0] rate_kbps(input logic [4:0] idx);
        logic [9:0] r;
        case (idx)
            5'd0:    r = 10'd32;
            5'd1:    r = 10'd40;
            5'd2:    r = 10'd48;
            5'd3:    r = 10'd56;
            5'd4:    r = 10'd64;
            5'd5:    r = 10'd80;
            5'd6:    r = 10'd96;
            5'd7:    r = 10'd112;
            5'd8:    r = 10'd128;
            5'd9:    r = 10'd160;
            5'd10:   r = 10'd192;
            5'd11:   r = 10'd224;
            5'd12:   r = 10'd256;
            5'd13:   r = 10'd320;
            5'd14:   r = 10'd384;
            5'd15:   r = 10'd448;
            5'd16:   r = 10'd512;
            5'd17:   r = 10'd576;
            5'd18:   r = 10'd640;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    // 16-bit words per frame at 44.1 kHz, 320 * rate / 147 rounded down
    function automatic logic [10:0] words_44k(input logic [4:0] idx);
        logic [10:0] w;
        case (idx)
            5'd0:    w = 11'd69;
            5'd1:    w = 11'd87;
            5'd2:    w = 11'd104;
            5'd3:    w = 11'd121;
            5'd4:    w = 11'd139;
            5'd5:    w = 11'd174;
            5'd6:    w = 11'd208;
            5'd7:    w = 11'd243;
            5'd8:    w = 11'd278;
            5'd9:    w = 11'd348;
            5'd10:   w = 11'd417;
            5'd11:   w = 11'd487;
            5'd12:   w = 11'd557;
            5'd13:   w = 11'd696;
            5'd14:   w = 11'd835;
            5'd15:   w = 11'd975;
            5'd16:   w = 11'd1114;
            5'd17:   w = 11'd1253;
            5'd18:   w = 11'd1393;
            default: w = 11'd0;
        endcase
        return w;
    endfunction

    // compare mask for the compression byte, by acmod
    function automatic logic [7:0] cmp_mask(input logic [2:0] acmod);
        logic [7:0] m;
        case (acmod)
            3'd0, 3'd1:             m = 8'h80;
            3'd2, 3'd3, 3'd4, 3'd6: m = 8'hE0;
            3'd5, 3'd7:             m = 8'hF8;
            default:                m = 8'h80;
        endcase
        return m;
    endfunction

    // LFE bit position in the acmod byte depends on acmod
    function automatic logic lfe_flag(input logic [2:0] acmod, input logic [7:0] acbyte);
        logic f;
        case (acmod)
            3'd0, 3'd1:             f = acbyte[4];
            3'd2, 3'd3, 3'd4, 3'd6: f = acbyte[2];
            3'd5, 3'd7:             f = acbyte[0];
            default:                f = 1'b0;
        endcase
        return f;
    endfunction

endpackage

FILE: src/ac3_header_decode_compare_unit.sv
// AC-3 sync header decoder with comparison against the last valid header.
//
//  channel | ports                       | payload
//  --------+-----------------------------+-------------------------------
//  input   | s_valid, s_ready, s_data    | hdr_in_t, six header bytes
//  result  | m_valid, m_ready, m_data    | hdr_out_t, one result per beat
//
//  One beat per cycle sustained while m_ready is high; the path runs through an input register and a result register.
//  The stored reference is read on every input-to-result transfer and written on those with a valid header.
//  aresetn is synchronous and active low; it empties both registers and the reference.
//  A stalled result holds the input register; a new beat enters while it is empty or moving on.
module ac3_header_decode_compare_unit
    import ac3hdc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hdr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hdr_out_t m_data
);

    logic     in_valid_reg;
    hdr_in_t  in_data_reg;
    logic     out_valid_reg;
    hdr_out_t out_data_reg;

    logic     ref_valid_reg;
    hdr_in_t  ref_data_reg;
    logic     ref_swap_reg;
    logic [7:0] ref_mask_reg;

    logic     advance;
    logic     s_fire;

    logic       sync_plain, sync_swap, hdr_ok;
    logic [7:0] c_fs, c_bsid, c_ac;
    logic [1:0] fscod;
    logic [5:0] frm;
    logic [2:0] acmod;
    logic [4:0] hcode;
    logic [1:0] half;
    logic [9:0] rate;
    logic [10:0] words44;
    logic       same_plain, same_swap, same;
    hdr_out_t   out_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        sync_plain = (in_data_reg.byte_zero == SYNC_HI) && (in_data_reg.byte_one == SYNC_LO);
        sync_swap  = (in_data_reg.byte_one == SYNC_HI) && (in_data_reg.byte_zero == SYNC_LO);
        c_fs   = sync_swap ? in_data_reg.byte_five  : in_data_reg.byte_four;
        c_bsid = sync_swap ? in_data_reg.byte_four  : in_data_reg.byte_five;
        c_ac   = sync_swap ? in_data_reg.byte_seven : in_data_reg.byte_six;
        fscod  = c_fs[7:6];
        frm    = c_fs[5:0];
        acmod  = c_ac[7:5];
        hcode  = c_bsid[7:3];
        hdr_ok = (sync_plain || sync_swap) && (c_bsid < BSID_LIMIT)
                 && (frm <= FRM_MAX) && (fscod != FSCOD_RSV);
        half   = (hcode > HALF_BASE) ? 2'(hcode - HALF_BASE) : 2'd0;
        rate    = rate_kbps(frm[5:1]);
        words44 = words_44k(frm[5:1]);

        same_plain = (ref_data_reg.byte_zero == in_data_reg.byte_zero)
                  && (ref_data_reg.byte_one == in_data_reg.byte_one)
                  && ((ref_data_reg.byte_four & FRM_PAD_MASK)
                      == (in_data_reg.byte_four & FRM_PAD_MASK))
                  && (ref_data_reg.byte_five == in_data_reg.byte_five)
                  && (ref_data_reg.byte_six == in_data_reg.byte_six)
                  && ((ref_data_reg.byte_seven & ref_mask_reg)
                      == (in_data_reg.byte_seven & ref_mask_reg));
        same_swap  = (ref_data_reg.byte_zero == in_data_reg.byte_zero)
                  && (ref_data_reg.byte_one == in_data_reg.byte_one)
                  && (ref_data_reg.byte_four == in_data_reg.byte_four)
                  && ((ref_data_reg.byte_five & FRM_PAD_MASK)
                      == (in_data_reg.byte_five & FRM_PAD_MASK))
                  && (ref_data_reg.byte_seven == in_data_reg.byte_seven)
                  && ((ref_data_reg.byte_six & ref_mask_reg)
                      == (in_data_reg.byte_six & ref_mask_reg));
        same = ref_valid_reg && (ref_swap_reg ? same_swap : same_plain);

        out_next = '0;
        out_next.same_as_reference = same;
        if (hdr_ok) begin
            out_next.header_ok      = 1'b1;
            out_next.little_endian  = sync_swap;
            out_next.channel_mode   = acmod;
            out_next.lfe_present    = lfe_flag(acmod, c_ac);
            out_next.dolby_surround = (acmod == ACMOD_STEREO) && (c_ac[4:3] == DSURMOD_ON);
            case (fscod)
                FSCOD_48K: begin
                    out_next.frame_bytes   = {rate, 2'b00};
                    out_next.audio_rate_hz = RATE_48K >> half;
                end
                FSCOD_44K: begin
                    out_next.frame_bytes   = {words44 + {10'd0, frm[0]}, 1'b0};
                    out_next.audio_rate_hz = RATE_44K >> half;
                end
                FSCOD_32K: begin
                    out_next.frame_bytes   = {rate, 2'b00} + {1'b0, rate, 1'b0};
                    out_next.audio_rate_hz = RATE_32K >> half;
                end
                default: begin
                    out_next.frame_bytes   = '0;
                    out_next.audio_rate_hz = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ref_valid_reg <= 1'b0;
            ref_data_reg  <= '0;
            ref_swap_reg  <= 1'b0;
            ref_mask_reg  <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_data;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_next;
                if (hdr_ok) begin
                    ref_valid_reg <= 1'b1;
                    ref_data_reg  <= in_data_reg;
                    ref_swap_reg  <= sync_swap;
                    ref_mask_reg  <= cmp_mask(acmod);
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.header_ok) |-> (m_data.frame_bytes != 12'd0
                                           && m_data.audio_rate_hz != 16'd0))
        else $error("accepted header with zero frame length or rate");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.header_ok) |-> (m_data.frame_bytes == 12'd0
            && m_data.audio_rate_hz == 16'd0 && m_data.channel_mode == 3'd0
            && !m_data.little_endian))
        else $error("rejected header carries decoded fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.same_as_reference) |-> m_data.header_ok)
        else $error("reference match on a rejected header");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hdr_ok) |=> (ref_valid_reg && m_data.header_ok))
        else $error("valid header did not update the reference");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> (in_valid_reg
                                                         && $stable(in_data_reg)))
        else $error("input register changed under a stalled result");

endmodule

FILE: test/ac3_header_decode_compare_unit_tb.sv
// Testbench for the AC-3 header decode and compare unit: directed table, then random headers.
`timescale 1ns / 1ps

module ac3_header_decode_compare_unit_tb;
    import ac3hdc_pkg::*;

    localparam int RANDOM_HEADERS = 1650;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum logic [1:0] {ORDER_NONE, ORDER_BYTE, ORDER_SWAPPED} hdr_order_t;

    typedef struct {
        hdr_in_t  hdr;
        bit       typed;
        hdr_out_t want;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hdr_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hdr_out_t m_data;

    logic [47:0] stored_header;
    bit          stored_valid;
    hdr_out_t    pending_results[$];
    dir_row_t    dir_rows[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;

    ac3_header_decode_compare_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic hdr_order_t find_order(input logic [47:0] raw, output logic [47:0] cano);
        cano = raw;
        if (raw[47:40] == SYNC_HI && raw[39:32] == SYNC_LO) begin
            return ORDER_BYTE;
        end
        if (raw[39:32] == SYNC_HI && raw[47:40] == SYNC_LO) begin
            cano = {raw[39:32], raw[47:40], raw[23:16], raw[31:24], raw[7:0], raw[15:8]};
            return ORDER_SWAPPED;
        end
        return ORDER_NONE;
    endfunction

    function automatic bit fields_legal(input logic [47:0] cano);
        return cano[23:16] < BSID_LIMIT && cano[29:24] <= FRM_MAX && cano[31:30] != FSCOD_RSV;
    endfunction

    function automatic int kbit_rate(input int idx);
        case (idx)
            0: return 32;    1: return 40;    2: return 48;    3: return 56;
            4: return 64;    5: return 80;    6: return 96;    7: return 112;
            8: return 128;   9: return 160;   10: return 192;  11: return 224;
            12: return 256;  13: return 320;  14: return 384;  15: return 448;
            16: return 512;  17: return 576;  default: return 640;
        endcase
    endfunction

    function automatic logic [7:0] compression_mask(input logic [2:0] acmod);
        case (acmod)
            3'd0, 3'd1: return 8'h80;
            3'd5, 3'd7: return 8'hF8;
            default:    return 8'hE0;
        endcase
    endfunction

    function automatic hdr_out_t decode_header(input hdr_in_t hdr);
        logic [47:0] raw;
        logic [47:0] cano;
        logic [47:0] ref_cano;
        logic [7:0]  mask;
        logic [7:0]  acbyte;
        logic [4:0]  hcode;
        hdr_order_t  order;
        hdr_order_t  ref_order;
        hdr_out_t    res;
        int          half;
        int          kbps;
        int          frm;
        res = '0;
        raw = hdr;
        order = find_order(raw, cano);
        if (stored_valid) begin
            ref_order = find_order(stored_header, ref_cano);
            if (ref_order != ORDER_NONE && fields_legal(ref_cano)) begin
                mask = compression_mask(ref_cano[15:13]);
                if (ref_order == ORDER_BYTE) begin
                    res.same_as_reference = stored_header[47:32] == raw[47:32] &&
                        (stored_header[31:24] & FRM_PAD_MASK) == (raw[31:24] & FRM_PAD_MASK) &&
                        stored_header[23:8] == raw[23:8] &&
                        (stored_header[7:0] & mask) == (raw[7:0] & mask);
                end else begin
                    res.same_as_reference = stored_header[47:24] == raw[47:24] &&
                        (stored_header[23:16] & FRM_PAD_MASK) == (raw[23:16] & FRM_PAD_MASK) &&
                        (stored_header[15:8] & mask) == (raw[15:8] & mask) &&
                        stored_header[7:0] == raw[7:0];
                end
            end
        end
        if (order != ORDER_NONE && fields_legal(cano)) begin
            acbyte = cano[15:8];
            hcode = cano[23:19];
            half = (hcode > HALF_BASE) ? int'(hcode - HALF_BASE) : 0;
            frm = int'(cano[29:24]);
            kbps = kbit_rate(frm >> 1);
            res.header_ok = 1'b1;
            res.little_endian = (order == ORDER_SWAPPED);
            res.channel_mode = acbyte[7:5];
            res.dolby_surround = acbyte[7:5] == ACMOD_STEREO && acbyte[4:3] == DSURMOD_ON;
            case (acbyte[7:5])
                3'd0, 3'd1: res.lfe_present = acbyte[4];
                3'd5, 3'd7: res.lfe_present = acbyte[0];
                default:    res.lfe_present = acbyte[2];
            endcase
            case (cano[31:30])
                FSCOD_48K: begin
                    res.frame_bytes = 12'(4 * kbps);
                    res.audio_rate_hz = RATE_48K >> half;
                end
                FSCOD_44K: begin
                    res.frame_bytes = 12'(2 * ((320 * kbps) / 147 + (frm & 1)));
                    res.audio_rate_hz = RATE_44K >> half;
                end
                default: begin
                    res.frame_bytes = 12'(6 * kbps);
                    res.audio_rate_hz = RATE_32K >> half;
                end
            endcase
            stored_header = raw;
            stored_valid = 1'b1;
        end
        return res;
    endfunction

    function automatic hdr_in_t make_header(input bit swapped, input logic [1:0] fscod,
                                            input logic [5:0] frm, input logic [7:0] bsid_byte,
                                            input logic [7:0] acbyte, input logic [7:0] comp);
        if (swapped) begin
            return {SYNC_LO, SYNC_HI, bsid_byte, fscod, frm, comp, acbyte};
        end
        return {SYNC_HI, SYNC_LO, fscod, frm, bsid_byte, acbyte, comp};
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic add_row(input hdr_in_t hdr, input bit typed, input hdr_out_t want);
        dir_row_t row;
        row.hdr = hdr;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic send_header(input hdr_in_t hdr, input bit typed, input hdr_out_t typed_want);
        hdr_out_t want;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= hdr;
        do @(posedge aclk); while (!s_ready);
        want = decode_header(hdr);
        if (typed) begin
            want = typed_want;
        end
        pending_results.push_back(want);
        @(negedge aclk);
    endtask

    // receiver stall pattern, reloaded whenever pat_left runs out
    logic [31:0] stall_pat = '1;
    int          pat_left = 0;
    always @(negedge aclk) begin
        if (pat_left == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = '1;
                1: stall_pat = $urandom;
                2: stall_pat = $urandom | $urandom;
                default: stall_pat = ($urandom & $urandom) | 32'h1;
            endcase
            pat_left = $urandom_range(20, 200);
        end
        m_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
        pat_left--;
    end

    always @(posedge aclk) begin
        hdr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no header pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("header_ok", want.header_ok, m_data.header_ok);
                check_field("little_endian", want.little_endian, m_data.little_endian);
                check_field("frame_bytes", want.frame_bytes, m_data.frame_bytes);
                check_field("audio_rate_hz", want.audio_rate_hz, m_data.audio_rate_hz);
                check_field("channel_mode", want.channel_mode, m_data.channel_mode);
                check_field("lfe_present", want.lfe_present, m_data.lfe_present);
                check_field("dolby_surround", want.dolby_surround, m_data.dolby_surround);
                check_field("same_as_reference", want.same_as_reference,
                            m_data.same_as_reference);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        hdr_in_t     hdr;
        hdr_in_t     last_sent;
        logic [63:0] rnd;
        int          sel;
        logic [1:0]  fscod;
        logic [5:0]  frm;
        logic [7:0]  bsid_byte;
        logic [7:0]  flip;

        stored_header = '0;
        stored_valid = 1'b0;

        add_row(48'h0000_0000_0000, 1'b1, '0);
        add_row(48'h0B77_0000_0000, 1'b1,
                {1'b1, 1'b0, 12'd128, RATE_48K, 3'd0, 1'b0, 1'b0, 1'b0});
        add_row(48'h0B77_0000_0000, 1'b1,
                {1'b1, 1'b0, 12'd128, RATE_48K, 3'd0, 1'b0, 1'b0, 1'b1});
        add_row(48'h0B77_A55F_FFFF, 1'b1,
                {1'b1, 1'b0, 12'd3840, 16'd4000, 3'd7, 1'b1, 1'b0, 1'b0});
        add_row(48'h770B_4841_0050, 1'b0, '0);
        add_row(48'h0B76_0000_0000, 1'b1, '0);
        add_row(48'h0B77_0060_0000, 1'b1, '0);
        add_row(48'h0B77_2600_0000, 1'b1, '0);
        add_row(48'h0B77_C000_0000, 1'b1, '0);
        add_row(48'h770B_6000_0000, 1'b1, '0);
        add_row(48'h7777_0000_0000, 1'b1, '0);
        add_row(48'h0B77_4008_5000, 1'b0, '0);
        add_row(48'h0B77_4108_501F, 1'b0, '0);
        add_row(48'h0B77_4108_5020, 1'b0, '0);
        add_row(48'h0B77_0A10_3000, 1'b0, '0);
        add_row(48'h0B77_0C18_6400, 1'b0, '0);
        add_row(48'h0B77_4E20_8400, 1'b0, '0);
        add_row(48'h0B77_8F28_A100, 1'b0, '0);
        add_row(48'h0B77_1230_C400, 1'b0, '0);
        add_row(48'h770B_5002_00E0, 1'b0, '0);
        add_row(48'h0B77_0440_C400, 1'b0, '0);
        add_row(48'h770B_5003_07E0, 1'b0, '0);
        add_row(48'h770B_5003_08E0, 1'b0, '0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_header(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].want);
        end

        last_sent = dir_rows[dir_rows.size() - 1].hdr;
        for (int n = 0; n < RANDOM_HEADERS; n++) begin
            sel = $urandom_range(0, 99);
            rnd = {$urandom, $urandom};
            if (sel < 12) begin
                hdr = rnd[47:0];
            end else if (sel < 16) begin
                hdr = rnd[47:0];
                if (rnd[48]) begin
                    hdr.byte_zero = SYNC_HI;
                    hdr.byte_one = SYNC_LO;
                end else begin
                    hdr.byte_zero = SYNC_LO;
                    hdr.byte_one = SYNC_HI;
                end
            end else if (sel < 40) begin
                hdr = last_sent;
                flip = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
                if (hdr.byte_zero == SYNC_HI) begin
                    hdr.byte_four[0] = hdr.byte_four[0] ^ rnd[0];
                    hdr.byte_seven = hdr.byte_seven ^ flip;
                end else begin
                    hdr.byte_five[0] = hdr.byte_five[0] ^ rnd[0];
                    hdr.byte_six = hdr.byte_six ^ flip;
                end
            end else begin
                fscod = ($urandom_range(0, 15) == 0) ? FSCOD_RSV : 2'($urandom_range(0, 2));
                frm = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(38, 63))
                                                   : 6'($urandom_range(0, 37));
                bsid_byte = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(8'h60, 8'hFF))
                                                         : 8'($urandom_range(0, 8'h5F));
                hdr = make_header(rnd[63], fscod, frm, bsid_byte, rnd[15:8], rnd[7:0]);
            end
            last_sent = hdr;
            send_header(hdr, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
